@@ hdl/ple_pkg.sv @@
// Shared types, opcodes and constants for the positional list engine.
package ple_pkg;

    localparam int DATA_W             = 32;
    localparam int COUNT_W            = 5;
    localparam int POS_W              = 5;
    localparam int LIST_DEPTH_DEFAULT = 16;
    localparam int CAP_W              = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    // Register index of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_VALUE = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      cmp_en;
        logic      in_range;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [POS_W-1:0] position;
        data_t            value;
    } in_word_t;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] item_count;
    } out_word_t;

endpackage

@@ hdl/positional_list_engine.sv @@
// Top level of the positional list engine: control, cell chain, search and ports.
//
//   channel  | direction | handshake          | word
//   ---------+-----------+--------------------+-----------------------------------
//   in       | input     | in_valid/in_stall  | opcode, position, value
//   out      | output    | out_valid/out_stall| ok, found_position, item_count
//   config   | input     | APB psel/penable   | capacity_limit at byte address 0
//
// One word is accepted per cycle while in_stall is low; its result passes stage one, then the output register.
// The shift of insert and delete and the compare of locate happen in the cell chain at
// the accepting edge; the first-match search over the flagged cells fills the output register.
// Reset clears the count and the handshake state and sets the capacity to 16; entries are
// not cleared. A stalled output holds its word, and the input stalls while both stages are
// full and the output is stalled.
module positional_list_engine #(
    parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ple_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ple_pkg::out_word_t            out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ple_pkg::PADDR_W-1:0]   paddr,
    input  logic [ple_pkg::PDATA_W-1:0]   pwdata,
    output logic [ple_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IW_MIN   = 6;
    localparam int IW_DEPTH = $clog2(LIST_DEPTH + 2);
    localparam int IW       = (IW_DEPTH > IW_MIN) ? IW_DEPTH : IW_MIN;
    localparam int SEARCH_W = (LIST_DEPTH < 31) ? LIST_DEPTH : 31;

    logic [ple_pkg::CAP_W-1:0]   cap_reg;
    logic [ple_pkg::CAP_W-1:0]   cap_next;
    logic [ple_pkg::COUNT_W-1:0] count_reg;
    logic [ple_pkg::COUNT_W-1:0] count_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_ok_reg;
    logic                        s1_locate_reg;
    logic [ple_pkg::COUNT_W-1:0] s1_count_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ple_pkg::out_word_t          out_word_reg;
    ple_pkg::out_word_t          out_word_next;

    logic          accept;
    logic          s1_move;
    logic          cfg_write;
    logic [IW-1:0] pos_x;
    logic [IW-1:0] cnt_x;
    logic [IW-1:0] cap_x;
    logic [IW-1:0] eff_cap;
    logic          is_insert;
    logic          is_delete;
    logic          is_locate;
    logic          ins_ok;
    logic          del_ok;

    ple_pkg::data_t            cell_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]     cell_match;
    logic [ple_pkg::POS_W-1:0] found;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cap_next  = (cfg_write && (paddr[2] == ple_pkg::REG_CAPACITY))
                       ? pwdata[ple_pkg::CAP_W-1:0] : cap_reg;
    assign prdata    = (paddr[2] == ple_pkg::REG_CAPACITY)
                       ? {{(ple_pkg::PDATA_W - ple_pkg::CAP_W){1'b0}}, cap_reg} : '0;

    // Handshake.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Operation decode against the current count.
    assign pos_x     = IW'(in_word.position);
    assign cnt_x     = IW'(count_reg);
    assign cap_x     = IW'(cap_reg);
    assign eff_cap   = (cap_x > IW'(LIST_DEPTH)) ? IW'(LIST_DEPTH) : cap_x;
    assign is_insert = (in_word.opcode == ple_pkg::OP_INSERT);
    assign is_delete = (in_word.opcode == ple_pkg::OP_DELETE);
    assign is_locate = (in_word.opcode == ple_pkg::OP_LOCATE);
    assign ins_ok    = is_insert && (pos_x != '0) && (pos_x <= cnt_x + IW'(1))
                       && (cnt_x < eff_cap);
    assign del_ok    = is_delete && (pos_x != '0) && (pos_x <= cnt_x);

    always_comb
    begin
        count_next = count_reg;
        if (accept && ins_ok)
        begin
            count_next = count_reg + ple_pkg::COUNT_W'(1);
        end
        else if (accept && del_ok)
        begin
            count_next = count_reg - ple_pkg::COUNT_W'(1);
        end
    end

    // Cell chain.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        localparam logic [IW-1:0] CELL_POS = IW'(i + 1);
        ple_pkg::cell_ctrl_t ctrl;
        ple_pkg::data_t      left;
        ple_pkg::data_t      right;

        always_comb
        begin
            ctrl.sel      = ple_pkg::SEL_HOLD;
            ctrl.cmp_en   = accept;
            ctrl.in_range = CELL_POS <= cnt_x;
            if (accept && ins_ok)
            begin
                if (CELL_POS == pos_x)
                begin
                    ctrl.sel = ple_pkg::SEL_VALUE;
                end
                else if ((CELL_POS > pos_x) && (CELL_POS <= cnt_x + IW'(1)))
                begin
                    ctrl.sel = ple_pkg::SEL_LEFT;
                end
            end
            else if (accept && del_ok)
            begin
                if ((CELL_POS >= pos_x) && (CELL_POS < cnt_x))
                begin
                    ctrl.sel = ple_pkg::SEL_RIGHT;
                end
            end
        end

        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_inner_left
            assign left = cell_data[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_inner_right
            assign right = cell_data[i+1];
        end

        ple_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left),
            .right (right),
            .value (in_word.value),
            .data  (cell_data[i]),
            .match (cell_match[i])
        );
    end

    // Positions above 31 cannot be reported, and the count never reaches past them.
    ple_first_match #(
        .WIDTH (SEARCH_W)
    ) u_first_match (
        .flags    (cell_match[SEARCH_W-1:0]),
        .position (found)
    );

    assign s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_comb
    begin
        out_word_next = out_word_reg;
        if (s1_move)
        begin
            out_word_next.item_count     = s1_count_reg;
            out_word_next.found_position = s1_locate_reg ? found : '0;
            out_word_next.ok             = s1_locate_reg ? (found != '0) : s1_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= ple_pkg::CAP_RESET;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg     <= ins_ok || del_ok;
            s1_locate_reg <= is_locate;
            s1_count_reg  <= count_next;
        end
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        IW'(count_reg) <= IW'(LIST_DEPTH))
        else $error("entry count exceeds list depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ins_ok) |=> (count_reg == $past(count_reg) + ple_pkg::COUNT_W'(1)))
        else $error("insert did not raise the count");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && del_ok) |=> (count_reg == $past(count_reg) - ple_pkg::COUNT_W'(1)))
        else $error("delete did not lower the count");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_locate_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_locate) |=> (count_reg == $past(count_reg)))
        else $error("locate changed the count");
`endif

endmodule

@@ hdl/ple_cell.sv @@
// One list cell: holds an entry, takes a neighbor's entry on a shift, and flags a match.
module ple_cell (
    input  logic                clk,
    input  ple_pkg::cell_ctrl_t ctrl,
    input  ple_pkg::data_t      left,
    input  ple_pkg::data_t      right,
    input  ple_pkg::data_t      value,
    output ple_pkg::data_t      data,
    output logic                match
);

    ple_pkg::data_t data_reg;
    ple_pkg::data_t data_next;
    logic           match_reg;
    logic           match_next;

    always_comb
    begin
        case (ctrl.sel)
            ple_pkg::SEL_HOLD:  data_next = data_reg;
            ple_pkg::SEL_LEFT:  data_next = left;
            ple_pkg::SEL_RIGHT: data_next = right;
            ple_pkg::SEL_VALUE: data_next = value;
            default:            data_next = data_reg;
        endcase
    end

    // The match is taken against the entry as it stood before this word.
    assign match_next = ctrl.cmp_en ? (ctrl.in_range && (data_reg == value)) : match_reg;

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ hdl/ple_first_match.sv @@
// Finds the lowest flagged cell and returns its 1-based position, or zero.
module ple_first_match #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]         flags,
    output logic [ple_pkg::POS_W-1:0] position
);

    logic [WIDTH-1:0] lowest;

    // Isolate the lowest set bit, then encode the one-hot result.
    assign lowest = flags & (~flags + WIDTH'(1));

    always_comb
    begin
        position = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (lowest[i])
            begin
                position = position | ple_pkg::POS_W'(i + 1);
            end
        end
    end

endmodule

@@ bench/positional_list_engine_tb.sv @@
// Testbench for the positional list engine: directed and random list operations checked against a predictor.
module positional_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEFAULT;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_SHOWN   = 10;

    localparam logic REG_SPARE = 1'b1;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE    = {REG_SPARE, 2'b00};
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam data_t MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam data_t MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_word_t           in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_word;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Predicted state of the list and its capacity register.
    data_t            list_mem [DEPTH];
    int               list_len = 0;
    logic [CAP_W-1:0] cap_reg  = CAP_RESET;
    out_word_t        list_answers [$];

    int mismatches     = 0;
    int sender_gap_pct = 0;
    int stall_pct      = 0;
    int cycle_count    = 0;

    positional_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("%0t ERROR %s", $time, what);
        end
    endfunction

    function automatic int usable_capacity();
        return (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    endfunction

    function automatic out_word_t apply_list_op(in_word_t w);
        out_word_t r;
        int        pos;
        r   = '0;
        pos = int'(w.position);
        case (w.opcode)
            OP_INSERT:
            begin
                if (pos >= 1 && pos <= list_len + 1 && list_len < usable_capacity())
                begin
                    for (int k = list_len; k >= pos; k--)
                    begin
                        list_mem[k] = list_mem[k-1];
                    end
                    list_mem[pos-1] = w.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (pos >= 1 && pos <= list_len)
                begin
                    for (int k = pos; k < list_len; k++)
                    begin
                        list_mem[k-1] = list_mem[k];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                for (int k = 0; k < list_len; k++)
                begin
                    if (r.found_position == '0 && list_mem[k] == w.value)
                    begin
                        r.found_position = POS_W'(k + 1);
                    end
                end
                r.ok = (r.found_position != '0);
            end
            default:
            begin
            end
        endcase
        r.item_count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:          return MIN_VAL;
            1:          return MAX_VAL;
            2, 3, 4, 5: return data_t'(int'($urandom_range(0, 7)) - 3);
            default:    return data_t'($urandom);
        endcase
    endfunction

    task automatic idle_input(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic issue_op(logic [1:0] op, int pos, data_t val);
        in_word_t w;
        w.opcode   = op;
        w.position = POS_W'(pos);
        w.value    = val;
        if (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct)
        begin
            idle_input($urandom_range(1, 13));
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        list_answers.push_back(apply_list_op(w));
    endtask

    // Stop sending and let every outstanding word come back.
    task automatic wait_drained();
        idle_input(1);
        while (list_answers.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr[PADDR_W-1:2] == REG_CAPACITY)
        begin
            cap_reg = data[CAP_W-1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        if (got !== want)
        begin
            note_mismatch($sformatf("register read at %0d: expected %0h, got %0h", addr, want, got));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(int cap);
        logic [PDATA_W-1:0] data;
        // Upper bits are junk; only the low bits of the word land in the register.
        data = {$urandom} & ~PDATA_W'(32'h1F) | PDATA_W'(cap);
        wait_drained();
        apb_write(ADDR_CAPACITY, data);
        apb_read_check(ADDR_CAPACITY, PDATA_W'(cap_reg));
    endtask

    task automatic issue_random_op(int grow_pct);
        int    roll;
        data_t probe;
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
        begin
            issue_op(OP_INSERT, $urandom_range(1, list_len + 1), pick_value());
        end
        else if (roll < 72 && list_len > 0)
        begin
            issue_op(OP_DELETE, $urandom_range(1, list_len), pick_value());
        end
        else if (roll < 90)
        begin
            probe = pick_value();
            if (list_len > 0 && $urandom_range(0, 2) != 0)
            begin
                probe = list_mem[$urandom_range(0, list_len - 1)];
            end
            issue_op(OP_LOCATE, $urandom_range(0, 31), probe);
        end
        else
        begin
            issue_op(2'($urandom_range(0, 3)), $urandom_range(0, 31), pick_value());
        end
    endtask

    task automatic test_directed_ops();
        sender_gap_pct = 30;
        stall_pct      = 20;
        issue_op(OP_LOCATE, 0, 0);
        issue_op(OP_DELETE, 1, 0);
        issue_op(OP_INSERT, 0, 1);
        issue_op(OP_INSERT, 2, 1);
        issue_op(OP_INSERT, 1, MIN_VAL);
        issue_op(OP_INSERT, 2, MAX_VAL);
        issue_op(OP_INSERT, 1, -1);
        issue_op(OP_INSERT, 2, 0);
        issue_op(OP_INSERT, 31, 7);
        // A duplicate further down, so locate must report the first one.
        issue_op(OP_INSERT, 3, -1);
        issue_op(OP_LOCATE, 31, -1);
        issue_op(OP_LOCATE, 0, MAX_VAL);
        issue_op(OP_LOCATE, 0, MAX_VAL - 1);
        issue_op(OP_UNUSED, 1, -1);
        issue_op(OP_DELETE, 0, 0);
        issue_op(OP_DELETE, 6, 0);
        issue_op(OP_DELETE, 31, 0);
        issue_op(OP_DELETE, 1, 0);
        issue_op(OP_DELETE, 4, 0);
        issue_op(OP_DELETE, 2, 0);
        issue_op(OP_LOCATE, 0, -1);
    endtask

    task automatic test_capacity_limits();
        sender_gap_pct = 15;
        stall_pct      = 10;
        wait_drained();
        apb_read_check(ADDR_CAPACITY, PDATA_W'(CAP_RESET));
        apb_write(ADDR_SPARE, PDATA_W'(3));
        apb_read_check(ADDR_CAPACITY, PDATA_W'(CAP_RESET));

        while (list_len < DEPTH)
        begin
            issue_op(OP_INSERT, $urandom_range(1, list_len + 1), pick_value());
        end
        issue_op(OP_INSERT, 1, 5);
        issue_op(OP_LOCATE, 0, list_mem[DEPTH-1]);

        // Values above the depth saturate.
        set_capacity(31);
        issue_op(OP_INSERT, list_len + 1, 5);
        issue_op(OP_DELETE, DEPTH, 0);
        issue_op(OP_INSERT, DEPTH, MIN_VAL);
        issue_op(OP_INSERT, 1, 5);

        // Capacity below the current count keeps the entries.
        set_capacity(4);
        issue_op(OP_INSERT, 1, 5);
        while (list_len > 4)
        begin
            issue_op(OP_DELETE, $urandom_range(1, list_len), pick_value());
        end
        issue_op(OP_INSERT, 2, 5);
        issue_op(OP_DELETE, 1, 0);
        issue_op(OP_INSERT, 4, 5);
        issue_op(OP_INSERT, 1, 6);

        set_capacity(0);
        issue_op(OP_INSERT, 1, 5);
        while (list_len > 0)
        begin
            issue_op(OP_DELETE, list_len, 0);
        end
        issue_op(OP_INSERT, 1, 5);

        set_capacity(1);
        issue_op(OP_INSERT, 1, MAX_VAL);
        issue_op(OP_INSERT, 1, 5);
        issue_op(OP_LOCATE, 0, MAX_VAL);
    endtask

    task automatic test_random_ops();
        int caps  [7] = '{16, 5, 31, 1, 0, 9, 16};
        int grow  [7] = '{50, 50, 35, 60, 40, 55, 30};
        int gaps  [7] = '{20, 0, 40, 10, 0, 25, 15};
        int stall [7] = '{10, 0, 25, 0, 30, 15, 5};
        for (int p = 0; p < 7; p++)
        begin
            set_capacity(caps[p]);
            sender_gap_pct = gaps[p];
            stall_pct      = stall[p];
            repeat (105) issue_random_op(grow[p]);
        end
    endtask

    task automatic test_steady_stream();
        set_capacity(16);
        sender_gap_pct = 0;
        stall_pct      = 0;
        repeat (100) issue_random_op(40);
    endtask

    initial
    begin
        int burst;
        forever
        begin
            @(negedge clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (list_answers.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word ok=%0d found=%0d count=%0d",
                    out_word.ok, out_word.found_position, out_word.item_count));
            end
            else
            begin
                want = list_answers.pop_front();
                if (out_word.ok !== want.ok || out_word.found_position !== want.found_position
                    || out_word.item_count !== want.item_count)
                begin
                    note_mismatch($sformatf(
                        "wrong word: expected ok=%0d found=%0d count=%0d, got ok=%0d found=%0d count=%0d",
                        want.ok, want.found_position, want.item_count,
                        out_word.ok, out_word.found_position, out_word.item_count));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("positional_list_engine: mismatch");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_ops();
        test_capacity_limits();
        test_random_ops();
        test_steady_stream();
        wait_drained();
        if (mismatches == 0 && list_answers.size() == 0)
        begin
            $display("positional_list_engine: match");
        end
        else
        begin
            $display("positional_list_engine: mismatch");
        end
        $finish;
    end

endmodule
